// ----- rtl/zfp_pkg.sv -----
`timescale 1ns / 1ps

package zfp_pkg;

  // Fixed field and state widths
  localparam int LINE_W      = 16;  // line count, saturated
  localparam int INDEX_W     = 17;  // line index, one bit wider than the count
  localparam int A_PULSE_W   = 25;
  localparam int B_PULSE_W   = 24;
  localparam int DWELL_W     = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 2;

  localparam logic [LINE_W-1:0]  LINE_MAX     = '1;
  localparam logic [DWELL_W-1:0] DWELL_FIRST  = 9'd50;
  localparam logic [DWELL_W-1:0] DWELL_SECOND = 9'd350;
  localparam logic [DWELL_W-1:0] DWELL_FINAL  = 9'd0;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_TOP_X,
    REG_LEFT_TOP_Y,
    REG_LEFT_BOTTOM_X,
    REG_LEFT_BOTTOM_Y,
    REG_RIGHT_TOP_X,
    REG_RIGHT_TOP_Y,
    REG_RIGHT_BOTTOM_X,
    REG_RIGHT_BOTTOM_Y
  } cfg_reg_t;

endpackage

// ----- rtl/zigzag_fill_path_generator.sv -----
`timescale 1ns / 1ps

// Channel   Bus                               Contents (lowest bit first)
// -------   -------------------------------   -----------------------------------------
// input     s_axis_tvalid/tready/tdata[7:0]   abort_request, zeros
// output    m_axis_tvalid/tready/tdata[63:0]  motor_a_dir, motor_a_pulses, motor_b_dir,
//                                             motor_b_pulses, dwell_ms, zeros
//           m_axis_tlast / m_axis_tuser[1:0]  final_move / job_done, aborted
// config    cfg_we, cfg_index, cfg_data       register index 0..7, coordinate value
//
// Each request yields one move. A move computes two coordinates, each one multiply and
// a restoring divide of COORD_BITS+18 steps through the shared subtractor (a final move
// and a zero length edge skip the divide). The first request of a job adds the line
// count: two squares, a COORD_BITS+1 step square root and rounding. Reset (rst,
// synchronous) clears the configuration, the job state and the result valid flag.
// The result register lets the next request enter while a move still waits on tready.
module zigzag_fill_path_generator
  import zfp_pkg::*;
#(
  parameter int COORD_BITS      = 16,
  parameter int PULSES_PER_UNIT = 160
) (
  input  logic                   clk,
  input  logic                   rst,
  // request channel
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // abort_request, zeros
  // move channel
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // a_dir, a_pulses, b_dir, b_pulses, dwell
  output logic                   m_axis_tlast,   // final_move
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // job_done, aborted
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_BITS-1:0]  cfg_data
);

  localparam int CB     = COORD_BITS;
  localparam int SQ_W   = 2 * CB + 1;          // squared edge length
  localparam int ALU_W  = 2 * CB + 2;          // shared subtractor
  localparam int DEN_W  = LINE_W + 1;          // 2 * line count
  localparam int REM_W  = DEN_W + 1;
  localparam int NUM_W  = CB + 18;             // rounded numerator magnitude
  localparam int CNT_W  = $clog2(NUM_W);
  localparam int PROD_W = 2 * LINE_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ_DX, S_SQ_DY, S_SQ_SUM, S_SQRT, S_SQ_RND,
    S_START, S_COORD, S_NUM, S_DIV, S_FIX, S_EMIT
  } state_t;

  state_t state;

  // configuration registers
  logic [CB-1:0] left_top_x, left_top_y, left_bottom_x, left_bottom_y;
  logic [CB-1:0] right_top_x, right_top_y, right_bottom_x, right_bottom_y;

  // job state
  logic               job_phase;
  logic [LINE_W-1:0]  line_total;
  logic [INDEX_W-1:0] line_index;
  logic               second_point;
  logic               abort_pending;

  // working registers
  logic [PROD_W-1:0] p;
  logic [SQ_W-1:0]   v, r;
  logic [CNT_W-1:0]  cnt;
  logic [REM_W-1:0]  rem;
  logic [NUM_W-1:0]  dq;
  logic              d_neg, num_neg;
  logic              axis, side_left;
  logic [CB-1:0]     px, py;
  logic              fin, fin_done, fin_abort;

  // result register
  logic                 out_valid;
  logic                 out_a_dir, out_b_dir, out_last, out_done, out_abort;
  logic [A_PULSE_W-1:0] out_a_pulses;
  logic [B_PULSE_W-1:0] out_b_pulses;
  logic [DWELL_W-1:0]   out_dwell;

  // combinational helpers
  logic [CB-1:0]     dx_abs, dy_abs, coord_a, coord_b, span_abs, coord_q, coord_new;
  logic              span_neg;
  logic [LINE_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] mul_prod;
  logic [SQ_W-1:0]   sq_bit, r_rnd;
  logic [ALU_W-1:0]  sub_a, sub_b;
  logic [ALU_W:0]    sub_diff;
  logic              sub_ok;
  logic [REM_W-1:0]  rem_shift;
  logic [NUM_W-1:0]  num_m, num_n;
  logic [CB:0]       pt_sum;
  logic [CB-1:0]     pt_diff;
  logic              emit_load;

  assign s_axis_tready = (state == S_IDLE);
  assign emit_load     = (state == S_EMIT) && (!out_valid || m_axis_tready);

  // Pick the endpoints of the coordinate being interpolated, and the left edge deltas
  always_comb begin
    dx_abs  = (left_bottom_x >= left_top_x) ? left_bottom_x - left_top_x
                                            : left_top_x - left_bottom_x;
    dy_abs  = (left_bottom_y >= left_top_y) ? left_bottom_y - left_top_y
                                            : left_top_y - left_bottom_y;
    if (side_left) begin
      coord_a = axis ? left_top_y : left_top_x;
      coord_b = axis ? left_bottom_y : left_bottom_x;
    end else begin
      coord_a = axis ? right_top_y : right_top_x;
      coord_b = axis ? right_bottom_y : right_bottom_x;
    end
    span_neg = coord_b < coord_a;
    span_abs = span_neg ? coord_a - coord_b : coord_b - coord_a;
  end

  // Shared multiplier
  always_comb begin
    unique case (state)
      S_SQ_DX: begin
        mul_a = LINE_W'(dx_abs);
        mul_b = LINE_W'(dx_abs);
      end
      S_SQ_DY: begin
        mul_a = LINE_W'(dy_abs);
        mul_b = LINE_W'(dy_abs);
      end
      default: begin
        mul_a = line_index[LINE_W-1:0];
        mul_b = LINE_W'(span_abs);
      end
    endcase
    mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Shared trial subtractor: square root digits and divider steps
  always_comb begin
    sq_bit    = SQ_W'(1) << (2 * cnt);
    rem_shift = {rem[REM_W-2:0], dq[NUM_W-1]};
    if (state == S_SQRT) begin
      sub_a = ALU_W'(v);
      sub_b = ALU_W'(r) + ALU_W'(sq_bit);
    end else begin
      sub_a = ALU_W'(rem_shift);
      sub_b = ALU_W'({line_total, 1'b0});
    end
    sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    sub_ok   = !sub_diff[ALU_W];
  end

  // Numerator terms, rounding and result point
  always_comb begin
    num_m     = NUM_W'({p, 1'b0});
    num_n     = NUM_W'(line_total);
    r_rnd     = r + SQ_W'(v > r);
    coord_q   = CB'(dq) + CB'(num_neg && (rem != '0));
    coord_new = num_neg ? coord_a - coord_q : coord_a + coord_q;
    pt_sum    = (CB+1)'(px) + (CB+1)'(py);
    pt_diff   = (px >= py) ? px - py : py - px;
  end

  // Sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      left_top_x     <= '0;
      left_top_y     <= '0;
      left_bottom_x  <= '0;
      left_bottom_y  <= '0;
      right_top_x    <= '0;
      right_top_y    <= '0;
      right_bottom_x <= '0;
      right_bottom_y <= '0;
      job_phase      <= 1'b0;
      line_total     <= '0;
      line_index     <= '0;
      second_point   <= 1'b0;
      abort_pending  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // write configuration
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_LEFT_TOP_X:     left_top_x     <= cfg_data;
          REG_LEFT_TOP_Y:     left_top_y     <= cfg_data;
          REG_LEFT_BOTTOM_X:  left_bottom_x  <= cfg_data;
          REG_LEFT_BOTTOM_Y:  left_bottom_y  <= cfg_data;
          REG_RIGHT_TOP_X:    right_top_x    <= cfg_data;
          REG_RIGHT_TOP_Y:    right_top_y    <= cfg_data;
          REG_RIGHT_BOTTOM_X: right_bottom_x <= cfg_data;
          REG_RIGHT_BOTTOM_Y: right_bottom_y <= cfg_data;
        endcase
      end

      // drop the move once taken
      if (m_axis_tvalid && m_axis_tready && !emit_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tdata[0]) begin
              abort_pending <= 1'b1;
            end
            state <= job_phase ? S_START : S_SQ_DX;
          end
        end
        // line count = round(sqrt(dx^2 + dy^2))
        S_SQ_DX: begin
          p     <= mul_prod;
          state <= S_SQ_DY;
        end
        S_SQ_DY: begin
          v     <= SQ_W'(p);
          p     <= mul_prod;
          state <= S_SQ_SUM;
        end
        S_SQ_SUM: begin
          v     <= v + SQ_W'(p);
          r     <= '0;
          cnt   <= CNT_W'(CB);
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sub_ok) begin
            v <= SQ_W'(sub_diff);
            r <= (r >> 1) + sq_bit;
          end else begin
            r <= r >> 1;
          end
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_SQ_RND;
          end
        end
        S_SQ_RND: begin
          line_total   <= (r_rnd > SQ_W'(LINE_MAX)) ? LINE_MAX : LINE_W'(r_rnd);
          line_index   <= '0;
          second_point <= 1'b0;
          job_phase    <= 1'b1;
          state        <= S_START;
        end
        // decide between a final move and a line point
        S_START: begin
          fin       <= 1'b0;
          fin_done  <= 1'b0;
          fin_abort <= 1'b0;
          axis      <= 1'b0;
          side_left <= line_index[0] == second_point;
          priority if (!second_point && (line_index > INDEX_W'(line_total))) begin
            fin      <= 1'b1;
            fin_done <= 1'b1;
            px       <= right_bottom_x;
            py       <= right_bottom_y;
            state    <= S_EMIT;
          end else if (!second_point && abort_pending) begin
            fin       <= 1'b1;
            fin_abort <= 1'b1;
            px        <= right_bottom_x;
            py        <= right_bottom_y;
            state     <= S_EMIT;
          end else begin
            state <= S_COORD;
          end
        end
        S_COORD: begin
          p     <= mul_prod;
          d_neg <= span_neg;
          if (line_total == '0) begin
            // zero length edge: stay at the top end
            if (axis) begin
              py    <= coord_a;
              state <= S_EMIT;
            end else begin
              px   <= coord_a;
              axis <= 1'b1;
            end
          end else begin
            state <= S_NUM;
          end
        end
        // numerator 2*i*d + n as sign and magnitude
        S_NUM: begin
          rem <= '0;
          cnt <= CNT_W'(NUM_W - 1);
          priority if (!d_neg) begin
            dq      <= num_m + num_n;
            num_neg <= 1'b0;
          end else if (num_m <= num_n) begin
            dq      <= num_n - num_m;
            num_neg <= 1'b0;
          end else begin
            dq      <= num_m - num_n;
            num_neg <= 1'b1;
          end
          state <= S_DIV;
        end
        S_DIV: begin
          if (sub_ok) begin
            rem <= REM_W'(sub_diff);
            dq  <= {dq[NUM_W-2:0], 1'b1};
          end else begin
            rem <= rem_shift;
            dq  <= {dq[NUM_W-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_FIX;
          end
        end
        // floor division: negative quotients round away from zero
        S_FIX: begin
          if (axis) begin
            py    <= coord_new;
            state <= S_EMIT;
          end else begin
            px    <= coord_new;
            axis  <= 1'b1;
            state <= S_COORD;
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            out_valid    <= 1'b1;
            out_a_dir    <= 1'b0;
            out_a_pulses <= A_PULSE_W'(pt_sum) * A_PULSE_W'(PULSES_PER_UNIT);
            out_b_dir    <= px < py;
            out_b_pulses <= B_PULSE_W'(pt_diff) * B_PULSE_W'(PULSES_PER_UNIT);
            out_last     <= fin;
            out_done     <= fin_done;
            out_abort    <= fin_abort;
            if (fin) begin
              out_dwell <= DWELL_FINAL;
              job_phase <= 1'b0;
              if (fin_abort) begin
                abort_pending <= 1'b0;
              end
            end else if (second_point) begin
              out_dwell    <= DWELL_SECOND;
              second_point <= 1'b0;
              line_index   <= line_index + 1'b1;
            end else begin
              out_dwell    <= DWELL_FIRST;
              second_point <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0, out_dwell, out_b_pulses, out_b_dir, out_a_pulses, out_a_dir};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = {out_abort, out_done};

  // A final move never claims both completion and abort
  a_final_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("final move flagged both done and aborted");

  // Dwell is zero exactly on the final move
  a_final_dwell: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[59:51] == DWELL_FINAL)))
    else $error("dwell does not match final move flag");

  // One request at a time
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while busy");

  // Loading a final move ends the job
  a_job_end: assert property (@(posedge clk) disable iff (rst)
    (emit_load && fin) |=> !job_phase)
    else $error("job still active after final move");

endmodule
